@@ hdl/fpds_pkg.sv @@
// Shared types and constants for the flux PLL data separator.
// Used by fpds_front, fpds_queue, fpds_back and the top level; depends on nothing.
package fpds_pkg;

    localparam int TICK_ACC_BITS = 20;
    localparam int ACC_W         = TICK_ACC_BITS;
    localparam int SAMPLE_W      = 16;
    localparam int OVF_TICKS     = 32'h10000;

    localparam int MODE_W   = 2;
    localparam int CENTRE_W = 13;
    localparam int TICK_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_PLL_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTRE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK     = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FIXED = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AUTH  = 2'd2;

    localparam logic [MODE_W-1:0]   MODE_RESET   = MODE_AUTH;
    localparam logic [CENTRE_W-1:0] CENTRE_RESET = 13'd2000;
    localparam logic [TICK_W-1:0]   TICK_RESET   = 7'd25;

    localparam int CLK_W     = 14;
    localparam int ZERO_W    = 14;
    localparam int ELAPSED_W = 25;
    localparam int RES_W     = 27;
    localparam int F2_W      = 15;
    localparam int DIV_W     = 26;
    localparam int N_W       = DIV_W + 1;
    localparam int MULB_W    = 16;
    localparam int PROD_W    = ACC_W + MULB_W;

    localparam int RUN_MAX     = 16383;
    localparam int ELAPSED_MAX = 33554431;
    localparam int RES_MAX     = 67108863;
    localparam int RES_MIN     = -67108864;

    // Floor division by 10 and by 30 for the small values seen here.
    localparam logic [MULB_W-1:0] RECIP_10 = 16'd52429;
    localparam int                RECIP_10_SH = 19;
    localparam logic [MULB_W-1:0] RECIP_30 = 16'd34953;
    localparam int                RECIP_30_SH = 20;

    localparam int QUEUE_DEPTH = 2;

    localparam int OUT_DATA_W = 56;
    localparam int OUT_PAD_W  = OUT_DATA_W - ZERO_W - ELAPSED_W - CLK_W;

    typedef struct packed {
        logic             index;
        logic [ACC_W-1:0] acc;
    } t_job;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [CENTRE_W-1:0] centre;
        logic [TICK_W-1:0]   tick;
    } t_cfg;

    typedef struct packed {
        logic [ZERO_W-1:0]    zero;
        logic                 sat;
        logic                 rev;
        logic [ELAPSED_W-1:0] elapsed;
        logic [CLK_W-1:0]     clk;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

@@ hdl/fpds_front.sv @@
// Input side of the data separator: accepts beats, folds overflow samples into
// the pending tick count and hands flux and index jobs to the queue. Uses fpds_pkg.
module fpds_front import fpds_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_func,
    input  logic [SAMPLE_W-1:0] i_ticks,
    input  t_queue_status       i_qstat,
    output logic                o_push,
    output t_job                o_job
);

    logic [ACC_W-1:0] r_pending;
    logic [ACC_W-1:0] n_pending;
    logic [ACC_W:0]   addend;
    logic [ACC_W:0]   acc_sum;
    logic [ACC_W-1:0] acc_sat;
    logic             accept;

    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;

    always_comb begin
        if (i_ticks == '0) begin
            addend = (ACC_W+1)'(OVF_TICKS);
        end else begin
            addend = (ACC_W+1)'(i_ticks);
        end
        acc_sum = {1'b0, r_pending} + addend;
        acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

        n_pending     = r_pending;
        o_push        = 1'b0;
        o_job.index   = i_func;
        o_job.acc     = acc_sat;
        if (accept) begin
            if (i_func) begin
                n_pending = '0;
                o_push    = 1'b1;
            end else if (i_ticks == '0) begin
                n_pending = acc_sat;
            end else begin
                n_pending = '0;
                o_push    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

endmodule

@@ hdl/fpds_queue.sv @@
// Short job queue between the front and the back of the data separator.
// Uses fpds_pkg for the job type and depth.
module fpds_queue import fpds_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_job          i_data,
    input  logic          i_pop,
    output t_job          o_data,
    output t_queue_status o_stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_data       = r_mem[r_rptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hdl/fpds_back.sv @@
// Back end of the data separator: residue update, serial cell-count divider,
// PLL period update and the output register. Uses fpds_pkg.
module fpds_back import fpds_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  t_job          i_job,
    input  t_queue_status i_qstat,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output t_result       o_result
);

    localparam int SUM_W = PROD_W + 1;
    localparam int CNT_W = $clog2(DIV_W);
    localparam int CK_W  = CLK_W + 2;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_MUL   = 10'b0000000010,
        S_SUM   = 10'b0000000100,
        S_SPLIT = 10'b0000001000,
        S_DIV   = 10'b0000010000,
        S_QUOT  = 10'b0000100000,
        S_ADJ   = 10'b0001000000,
        S_CMIN  = 10'b0010000000,
        S_CMAX  = 10'b0100000000,
        S_CLAMP = 10'b1000000000
    } t_state_core;

    // Emission is folded into a flag so the enum keeps one state per step.
    t_state_core r_state, n_state;
    logic        r_emit, n_emit;

    t_job                    r_job, n_job;
    logic [PROD_W-1:0]       r_prod, n_prod;
    logic signed [RES_W-1:0] r_f0, n_f0;
    logic [DIV_W-1:0]        r_div, n_div;
    logic [CLK_W-1:0]        r_rem, n_rem;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [N_W-1:0]          r_n, n_n;
    logic signed [F2_W-1:0]  r_f2, n_f2;
    logic                    r_adj_neg, n_adj_neg;
    logic                    r_div30, n_div30;
    logic signed [CK_W-1:0]  r_clk, n_clk;
    logic [CLK_W-1:0]        r_cmin, n_cmin;
    t_result                 r_res, n_res;
    logic signed [F2_W-1:0]  r_res_new, n_res_new;
    logic signed [RES_W-1:0] r_residue, n_residue;
    logic [CLK_W-1:0]        r_bit_clock, n_bit_clock;
    logic                    r_ovalid, n_ovalid;
    t_result                 r_out, n_out;

    logic [ACC_W-1:0]        mul_a;
    logic [MULB_W-1:0]       mul_b;
    logic [PROD_W-1:0]       prod;
    logic [CLK_W-1:0]        centre_clk;
    logic [CLK_W-1:0]        half_clk;
    logic signed [RES_W-1:0] h_s;
    logic signed [RES_W-1:0] c_s;
    logic signed [SUM_W-1:0] sum_s;
    logic signed [RES_W-1:0] f0_clamp;
    logic signed [RES_W-1:0] f1;
    logic signed [RES_W-1:0] d_s;
    logic [CLK_W:0]          rem_sh;
    logic                    rem_ge;
    logic [CLK_W:0]          rem_nx;
    logic signed [CK_W-1:0]  f2_calc;
    logic                    in_sync;
    logic [F2_W-1:0]         f2_abs;
    logic signed [F2_W-1:0]  diff;
    logic [F2_W-1:0]         diff_abs;
    logic [CLK_W-1:0]        xs;
    logic [PROD_W-1:0]       prod_sh;
    logic [CLK_W-1:0]        adj;
    logic signed [CK_W-1:0]  adj_s;
    logic [ACC_W-1:0]        ctr9;
    logic [ACC_W-1:0]        ctr11;
    logic [CLK_W-1:0]        cmax_raw;
    logic [CLK_W-1:0]        cmax;
    logic [CLK_W-1:0]        clk_clamped;
    logic signed [F2_W-1:0]  nf_half;
    logic signed [F2_W-1:0]  nf_sel;
    logic signed [RES_W:0]   elapsed_s;
    logic                    out_free;

    assign prod     = mul_a * mul_b;
    assign out_free = !r_ovalid || i_ready;
    assign o_valid  = r_ovalid;
    assign o_result = r_out;

    always_comb begin
        centre_clk = (i_cfg.centre == '0) ? CLK_W'(1) : {1'b0, i_cfg.centre};
        half_clk   = r_bit_clock >> 1;
        h_s        = $signed({{(RES_W-CLK_W){1'b0}}, half_clk});
        c_s        = $signed({{(RES_W-CLK_W){1'b0}}, r_bit_clock});

        sum_s = $signed({{(SUM_W-RES_W){r_residue[RES_W-1]}}, r_residue})
              + $signed({1'b0, r_prod});
        if (sum_s > SUM_W'(RES_MAX)) begin
            f0_clamp = RES_W'(RES_MAX);
        end else if (sum_s < SUM_W'(RES_MIN)) begin
            f0_clamp = RES_W'(RES_MIN);
        end else begin
            f0_clamp = sum_s[RES_W-1:0];
        end

        f1  = r_f0 - c_s;
        d_s = f1 - h_s;

        rem_sh = {r_rem, r_div[DIV_W-1]};
        rem_ge = (rem_sh >= {1'b0, r_bit_clock});
        rem_nx = rem_ge ? rem_sh - {1'b0, r_bit_clock} : rem_sh;

        f2_calc = $signed({2'b00, half_clk}) + $signed({2'b00, r_rem})
                - $signed({2'b00, r_bit_clock});

        in_sync  = (r_n != '0) && (r_n[N_W-1:2] == '0);
        f2_abs   = r_f2[F2_W-1] ? F2_W'(-r_f2) : F2_W'(r_f2);
        diff     = $signed({2'b00, i_cfg.centre}) - $signed({1'b0, r_bit_clock});
        diff_abs = diff[F2_W-1] ? F2_W'(-diff) : F2_W'(diff);
        if (in_sync) begin
            case (r_n[1:0])
                2'd1:    xs = f2_abs[CLK_W-1:0] >> 1;
                2'd3:    xs = f2_abs[CLK_W-1:0] >> 2;
                default: xs = f2_abs[CLK_W-1:0];
            endcase
        end else begin
            xs = diff_abs[CLK_W-1:0];
        end

        prod_sh = r_div30 ? (r_prod >> RECIP_30_SH) : (r_prod >> RECIP_10_SH);
        adj     = prod_sh[CLK_W-1:0];
        adj_s   = $signed({2'b00, adj});

        ctr9  = ACC_W'({4'b0000, i_cfg.centre} + {1'b0, i_cfg.centre, 3'b000});
        ctr11 = ACC_W'({4'b0000, i_cfg.centre} + {3'b000, i_cfg.centre, 1'b0}
                     + {1'b0, i_cfg.centre, 3'b000});

        prod_sh  = prod_sh;
        cmax_raw = CLK_W'(r_prod >> RECIP_10_SH);
        cmax     = (cmax_raw < r_cmin) ? r_cmin : cmax_raw;
        if (r_clk < $signed({2'b00, r_cmin})) begin
            clk_clamped = r_cmin;
        end else if (r_clk > $signed({2'b00, cmax})) begin
            clk_clamped = cmax;
        end else begin
            clk_clamped = r_clk[CLK_W-1:0];
        end

        nf_half = (r_f2 + $signed({{(F2_W-1){1'b0}}, r_f2[F2_W-1]})) >>> 1;
        nf_sel  = (i_cfg.mode == MODE_AUTH) ? nf_half : '0;
        elapsed_s = $signed({r_f0[RES_W-1], r_f0})
                  - $signed({{(RES_W+1-F2_W){nf_sel[F2_W-1]}}, nf_sel});
    end

    always_comb begin
        n_state     = r_state;
        n_emit      = r_emit;
        n_job       = r_job;
        n_prod      = r_prod;
        n_f0        = r_f0;
        n_div       = r_div;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_f2        = r_f2;
        n_adj_neg   = r_adj_neg;
        n_div30     = r_div30;
        n_clk       = r_clk;
        n_cmin      = r_cmin;
        n_res       = r_res;
        n_res_new   = r_res_new;
        n_residue   = r_residue;
        n_bit_clock = r_bit_clock;
        n_ovalid    = r_ovalid;
        n_out       = r_out;
        o_pop       = 1'b0;
        mul_a       = r_job.acc;
        mul_b       = MULB_W'(i_cfg.tick);

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        if (r_emit) begin
            if (out_free) begin
                n_ovalid    = 1'b1;
                n_out       = r_res;
                n_bit_clock = r_res.clk;
                n_residue   = {{(RES_W-F2_W){r_res_new[F2_W-1]}}, r_res_new};
                n_emit      = 1'b0;
                n_state     = S_IDLE;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_qstat.empty) begin
                        o_pop = 1'b1;
                        n_job = i_job;
                        if (i_job.index) begin
                            n_res.zero    = '0;
                            n_res.sat     = 1'b0;
                            n_res.rev     = 1'b1;
                            n_res.elapsed = '0;
                            n_res.clk     = centre_clk;
                            n_res_new     = '0;
                            n_emit        = 1'b1;
                        end else begin
                            n_state = S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    n_prod  = prod;
                    n_state = S_SUM;
                end
                S_SUM: begin
                    n_f0    = f0_clamp;
                    n_state = S_SPLIT;
                end
                S_SPLIT: begin
                    if (r_f0 < h_s) begin
                        n_residue = r_f0;
                        n_state   = S_IDLE;
                    end else if (f1 < h_s) begin
                        n_n     = '0;
                        n_f2    = f1[F2_W-1:0];
                        n_state = S_ADJ;
                    end else begin
                        n_div   = d_s[DIV_W-1:0];
                        n_rem   = '0;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                end
                S_DIV: begin
                    n_rem = rem_nx[CLK_W-1:0];
                    n_div = {r_div[DIV_W-2:0], rem_ge};
                    if (r_cnt == CNT_W'(DIV_W - 1)) begin
                        n_state = S_QUOT;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
                S_QUOT: begin
                    n_n     = {1'b0, r_div} + N_W'(1);
                    n_f2    = f2_calc[F2_W-1:0];
                    n_state = S_ADJ;
                end
                S_ADJ: begin
                    if (in_sync) begin
                        n_adj_neg = r_f2[F2_W-1];
                        n_div30   = (r_n[1:0] == 2'd2);
                    end else begin
                        n_adj_neg = diff[F2_W-1];
                        n_div30   = 1'b0;
                    end
                    mul_a   = ACC_W'(xs);
                    mul_b   = n_div30 ? RECIP_30 : RECIP_10;
                    n_prod  = prod;
                    n_state = S_CMIN;
                end
                S_CMIN: begin
                    n_clk   = $signed({2'b00, r_bit_clock}) + (r_adj_neg ? -adj_s : adj_s);
                    mul_a   = ctr9;
                    mul_b   = RECIP_10;
                    n_prod  = prod;
                    n_state = S_CMAX;
                end
                S_CMAX: begin
                    n_cmin  = (CLK_W'(r_prod >> RECIP_10_SH) == '0) ? CLK_W'(1)
                            : CLK_W'(r_prod >> RECIP_10_SH);
                    mul_a   = ctr11;
                    mul_b   = RECIP_10;
                    n_prod  = prod;
                    n_state = S_CLAMP;
                end
                S_CLAMP: begin
                    if (r_n > N_W'(RUN_MAX)) begin
                        n_res.zero = ZERO_W'(RUN_MAX);
                        n_res.sat  = 1'b1;
                    end else begin
                        n_res.zero = r_n[ZERO_W-1:0];
                        n_res.sat  = 1'b0;
                    end
                    n_res.rev = 1'b0;
                    if (elapsed_s < 0) begin
                        n_res.elapsed = '0;
                    end else if (elapsed_s > (RES_W+1)'(ELAPSED_MAX)) begin
                        n_res.elapsed = ELAPSED_W'(ELAPSED_MAX);
                    end else begin
                        n_res.elapsed = elapsed_s[ELAPSED_W-1:0];
                    end
                    n_res.clk = (i_cfg.mode == MODE_FIXED) ? centre_clk : clk_clamped;
                    n_res_new = nf_sel;
                    n_emit    = 1'b1;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_emit      <= 1'b0;
            r_ovalid    <= 1'b0;
            r_residue   <= '0;
            r_bit_clock <= CLK_W'(CENTRE_RESET);
        end else begin
            r_state     <= n_state;
            r_emit      <= n_emit;
            r_ovalid    <= n_ovalid;
            r_residue   <= n_residue;
            r_bit_clock <= n_bit_clock;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_prod    <= n_prod;
        r_f0      <= n_f0;
        r_div     <= n_div;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
        r_n       <= n_n;
        r_f2      <= n_f2;
        r_adj_neg <= n_adj_neg;
        r_div30   <= n_div30;
        r_clk     <= n_clk;
        r_cmin    <= n_cmin;
        r_res     <= n_res;
        r_res_new <= n_res_new;
        r_out     <= n_out;
    end

endmodule

@@ hdl/flux_pll_data_separator_unit.sv @@
// Flux PLL data separator, top level. Uses fpds_pkg, fpds_front, fpds_queue, fpds_back.
// An index job is popped in idle, registered as a result, then output once free;
// a merging flux job passes multiply, sum and split; one ending a run also passes the
// 26-step serial divider counting the zero cells (if any) and the PLL update. Overflow
// beats stay in front. One job at a time in the back; a two-beat queue lets input go on.
// Reset (synchronous, active low) clears the PLL state and loads the register defaults.
module flux_pll_data_separator_unit import fpds_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [SAMPLE_W-1:0]   i_s_axis_tdata,  // sample_ticks
    input  logic                  i_s_axis_tuser,  // func
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // zero_bits, elapsed_ns, clock_ns
    output logic [1:0]            o_m_axis_tuser,  // run_saturated, revolution_end
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg          r_cfg;
    t_queue_status qstat;
    t_job          push_job;
    t_job          head_job;
    logic          push;
    logic          pop;
    t_result       result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode   <= MODE_RESET;
            r_cfg.centre <= CENTRE_RESET;
            r_cfg.tick   <= TICK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PLL_MODE: r_cfg.mode   <= i_cfg_data[MODE_W-1:0];
                CFG_CENTRE:   r_cfg.centre <= i_cfg_data[CENTRE_W-1:0];
                CFG_TICK:     r_cfg.tick   <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    fpds_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_func  (i_s_axis_tuser),
        .i_ticks (i_s_axis_tdata),
        .i_qstat (qstat),
        .o_push  (push),
        .o_job   (push_job)
    );

    fpds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_stat  (qstat)
    );

    fpds_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_job    (head_job),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (result)
    );

    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, result.clk, result.elapsed, result.zero};
    assign o_m_axis_tuser = {result.rev, result.sat};

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for flux_pll_data_separator_unit: a directed table, then random
// flux streams under several PLL settings, each run checked against the table or a model.
// Depends on fpds_pkg and the RTL of the data separator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fpds_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SNAP     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SNAP_TOO = 2'd3;
    localparam int ADJ_PCT       = 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 80;
    localparam int QUIET_LIMIT   = 3000;
    localparam int REPORT_MAX    = 10;
    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 100;

    typedef struct packed {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic                 func;
        logic [15:0]          value;
        logic [4:0]           reps;
        logic                 known;
        t_result              run;
    } t_row;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  flux_valid = 1'b0;
    logic [SAMPLE_W-1:0]   flux_ticks = '0;
    logic                  flux_func  = 1'b0;
    logic                  flux_known = 1'b0;
    t_result               flux_known_run = '0;
    logic                  run_ready  = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    wire                   o_s_axis_tready;
    wire                   o_m_axis_tvalid;
    wire  [OUT_DATA_W-1:0] o_m_axis_tdata;
    wire  [1:0]            o_m_axis_tuser;

    logic [MODE_W-1:0] pll_mode_now  = MODE_RESET;
    int                centre_now    = CENTRE_RESET;
    int                tick_now      = TICK_RESET;
    longint            ticks_pending = 0;
    longint            residue_ns    = 0;
    longint            cell_ns       = CENTRE_RESET;

    t_result runs_due[$];
    t_row    plan[$];
    t_result predicted;
    t_result seen;
    int      runs_seen = 0;
    int      bad_runs  = 0;
    int      quiet     = 0;
    logic    calm      = 1'b0;
    logic    held      = 1'b0;

    logic [MODE_W-1:0] phase_mode [PHASES] = '{MODE_AUTH, MODE_SNAP, MODE_FIXED, MODE_AUTH,
                                               MODE_SNAP_TOO, MODE_AUTH, MODE_SNAP, MODE_AUTH};
    int phase_centre [PHASES] = '{2000, 1000, 4000, 500, 8000, 8191, 3333, 2000};
    int phase_tick   [PHASES] = '{25, 10, 50, 1, 100, 7, 127, 25};

    always #6 i_clk = ~i_clk;

    flux_pll_data_separator_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (flux_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (flux_ticks),
        .i_s_axis_tuser  (flux_func),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (run_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    function automatic t_result run_of(input int zeros, input int sat, input int rev,
                                       input int elapsed, input int clk);
        t_result r;
        r.zero    = zeros;
        r.sat     = sat;
        r.rev     = rev;
        r.elapsed = elapsed;
        r.clk     = clk;
        return r;
    endfunction

    function automatic t_row beat(input logic fn, input logic [15:0] ticks, input int reps,
                                  input logic known, input t_result run);
        t_row r;
        r         = '0;
        r.func    = fn;
        r.value   = ticks;
        r.reps    = reps;
        r.known   = known;
        r.run     = run;
        return r;
    endfunction

    function automatic t_row reg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
        t_row r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.value   = data;
        return r;
    endfunction

    function automatic string show(input t_result r);
        return $sformatf("zero=%0d sat=%0d rev=%0d elapsed=%0d clk=%0d",
                         r.zero, r.sat, r.rev, r.elapsed, r.clk);
    endfunction

    // Data separator model: returns 1 when the beat ends a run or is an index event.
    function automatic logic separate_flux(input logic fn, input logic [SAMPLE_W-1:0] ticks,
                                           output t_result run);
        longint acc, acc_top, f, c, h, n, ctr, clk, lo, hi, kept, spent;
        acc_top = (longint'(1) << ACC_W) - 1;
        ctr     = centre_now;
        run     = '0;
        if (fn) begin
            ticks_pending = 0;
            residue_ns    = 0;
            cell_ns       = (ctr != 0) ? ctr : 1;
            run.rev       = 1'b1;
            run.clk       = cell_ns;
            return 1'b1;
        end
        if (ticks == '0) begin
            acc           = ticks_pending + OVF_TICKS;
            ticks_pending = (acc > acc_top) ? acc_top : acc;
            return 1'b0;
        end
        acc = ticks_pending + longint'(ticks);
        if (acc > acc_top) acc = acc_top;
        ticks_pending = 0;
        f = residue_ns + acc * tick_now;
        if (f > RES_MAX) f = RES_MAX;
        if (f < RES_MIN) f = RES_MIN;
        c = (cell_ns != 0) ? cell_ns : 1;
        h = c / 2;
        if (f < h) begin
            residue_ns = f;
            return 1'b0;
        end
        f = f - c;
        n = (f >= h) ? (f - h) / c + 1 : 0;
        f = f - n * c;
        if (pll_mode_now != MODE_FIXED) begin
            clk = c;
            if (n >= 1 && n <= 3) clk = clk + (f / (n + 1)) / ADJ_PCT;
            else clk = clk + (ctr - clk) / ADJ_PCT;
            lo = ctr * (100 - ADJ_PCT) / 100;
            hi = ctr * (100 + ADJ_PCT) / 100;
            if (lo < 1) lo = 1;
            if (hi < lo) hi = lo;
            if (clk < lo) clk = lo;
            if (clk > hi) clk = hi;
            cell_ns = clk;
        end else begin
            cell_ns = (ctr != 0) ? ctr : 1;
        end
        kept       = (pll_mode_now == MODE_AUTH) ? f / 2 : 0;
        residue_ns = kept;
        spent      = (n + 1) * c + (f - kept);
        if (spent < 0) spent = 0;
        if (spent > ELAPSED_MAX) spent = ELAPSED_MAX;
        run.zero    = (n > RUN_MAX) ? RUN_MAX : n;
        run.sat     = (n > RUN_MAX);
        run.elapsed = spent;
        run.clk     = cell_ns;
        return 1'b1;
    endfunction

    task automatic send_beat(input logic fn, input logic [SAMPLE_W-1:0] ticks,
                             input logic known, input t_result run);
        if (!calm && $urandom_range(0, 5) == 0) begin
            flux_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        flux_valid     <= 1'b1;
        flux_func      <= fn;
        flux_ticks     <= ticks;
        flux_known     <= known;
        flux_known_run <= run;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_PLL_MODE: pll_mode_now = data[MODE_W-1:0];
            CFG_CENTRE:   centre_now   = data[CENTRE_W-1:0];
            CFG_TICK:     tick_now     = data[TICK_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic settle();
        flux_valid <= 1'b0;
        while (runs_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly MFM intervals of two to four cells with jitter, plus noise, index and overflow.
    task automatic pick_beat(output logic fn, output logic [SAMPLE_W-1:0] ticks);
        int sel, cells, spread, ns, t;
        sel   = $urandom_range(0, 99);
        fn    = 1'b0;
        ticks = $urandom_range(1, 65535);
        if (sel < 4) begin
            fn    = 1'b1;
            ticks = $urandom_range(0, 65535);
        end else if (sel < 9) begin
            ticks = '0;
        end else if (sel >= 19) begin
            if (sel < 29) begin
                ns = $urandom_range(0, centre_now / 2);
            end else begin
                cells  = $urandom_range(2, 4);
                spread = centre_now * 3 / 10;
                ns     = cells * centre_now + int'($urandom_range(0, spread)) - spread / 2;
            end
            t     = ns / ((tick_now != 0) ? tick_now : 1);
            ticks = (t < 1) ? 1 : (t > 65535) ? 16'hFFFF : t;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (flux_valid && o_s_axis_tready) begin
                if (separate_flux(flux_func, flux_ticks, predicted))
                    runs_due.push_back(flux_known ? flux_known_run : predicted);
            end
            if (o_m_axis_tvalid && run_ready) begin
                seen.zero    = o_m_axis_tdata[ZERO_W-1:0];
                seen.elapsed = o_m_axis_tdata[ZERO_W+ELAPSED_W-1:ZERO_W];
                seen.clk     = o_m_axis_tdata[ZERO_W+ELAPSED_W+CLK_W-1:ZERO_W+ELAPSED_W];
                seen.sat     = o_m_axis_tuser[0];
                seen.rev     = o_m_axis_tuser[1];
                runs_seen++;
                if (runs_due.size() == 0 || seen !== runs_due[0]) begin
                    bad_runs++;
                    if (bad_runs <= REPORT_MAX)
                        $display("run %0d: expected %s, got %s", runs_seen,
                                 (runs_due.size() != 0) ? show(runs_due[0]) : "nothing",
                                 show(seen));
                end
                if (runs_due.size() != 0) predicted = runs_due.pop_front();
            end
            if ((flux_valid && o_s_axis_tready) || (o_m_axis_tvalid && run_ready)) quiet = 0;
            else quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Output side: random stalls, and one long hold-off so that the input backs up.
    initial begin
        forever begin
            @(negedge i_clk);
            if (!held && runs_seen >= 150) begin
                held = 1'b1;
                run_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                run_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                run_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                run_ready <= 1'b1;
            end else begin
                run_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic                fn;
        logic [SAMPLE_W-1:0] ticks;
        plan.push_back(beat(1'b1, 16'h0000, 1, 1'b1, run_of(0, 0, 1, 0, 2000)));
        plan.push_back(beat(1'b0, 16'd160, 1, 1'b1, run_of(1, 0, 0, 4000, 2000)));
        plan.push_back(beat(1'b0, 16'd20, 1, 1'b0, '0));
        plan.push_back(beat(1'b0, 16'd140, 1, 1'b1, run_of(1, 0, 0, 4000, 2000)));
        plan.push_back(beat(1'b0, 16'h0000, 1, 1'b0, '0));
        plan.push_back(beat(1'b0, 16'hFFFF, 1, 1'b0, '0));
        plan.push_back(beat(1'b1, 16'hFFFF, 1, 1'b1, run_of(0, 0, 1, 0, 2000)));
        plan.push_back(reg_write(CFG_PLL_MODE, MODE_SNAP));
        plan.push_back(reg_write(CFG_CENTRE, 500));
        plan.push_back(reg_write(CFG_TICK, 100));
        plan.push_back(beat(1'b0, 16'h0000, 16, 1'b0, '0));
        plan.push_back(beat(1'b0, 16'hFFFF, 1, 1'b1,
                            run_of(RUN_MAX, 1, 0, ELAPSED_MAX, 550)));
        plan.push_back(beat(1'b1, 16'h0000, 1, 1'b1, run_of(0, 0, 1, 0, 500)));
        plan.push_back(reg_write(CFG_PLL_MODE, MODE_FIXED));
        plan.push_back(reg_write(CFG_CENTRE, 8191));
        plan.push_back(reg_write(CFG_TICK, 1));
        plan.push_back(beat(1'b0, 16'hFFFF, 1, 1'b0, '0));
        plan.push_back(beat(1'b0, 16'd24573, 1, 1'b0, '0));
        plan.push_back(reg_write(CFG_PLL_MODE, MODE_SNAP_TOO));
        plan.push_back(reg_write(CFG_CENTRE, 0));
        plan.push_back(beat(1'b1, 16'h5555, 1, 1'b1, run_of(0, 0, 1, 0, 1)));
        plan.push_back(beat(1'b0, 16'd7, 1, 1'b0, '0));
        plan.push_back(reg_write(CFG_TICK, 0));
        plan.push_back(beat(1'b0, 16'd500, 1, 1'b0, '0));
        plan.push_back(beat(1'b1, 16'hAAAA, 1, 1'b1, run_of(0, 0, 1, 0, 1)));

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                settle();
                write_reg(plan[k].reg_idx, plan[k].value[CFG_DATA_W-1:0]);
            end else begin
                repeat (plan[k].reps)
                    send_beat(plan[k].func, plan[k].value, plan[k].known, plan[k].run);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            write_reg(CFG_PLL_MODE, phase_mode[ph]);
            write_reg(CFG_CENTRE, phase_centre[ph]);
            write_reg(CFG_TICK, phase_tick[ph]);
            calm = (ph == PHASES - 1);
            for (int j = 0; j < PHASE_BEATS; j++) begin
                pick_beat(fn, ticks);
                send_beat(fn, ticks, 1'b0, '0);
            end
        end

        settle();
        if (bad_runs == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
